FILE: rtl/nrmc_pkg.sv
// Shared types, constants and helper functions for the RMC fix parser.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package nrmc_pkg;

	// Defaults for the top-level parameters
	localparam int FRACTION_DIGITS_DEF = 5;
	localparam int MAX_COMMAS_DEF      = 12;

	// Parser state widths
	localparam int COMMA_W = 4;
	localparam int FRAC_W  = 3;
	localparam int ACC_W   = 34;  // shared number unit, widest accumulator

	// Accumulators hold value * 10^FRACTION_DIGITS
	localparam int LAT_ACC_W = 30;
	localparam int LON_ACC_W = 34;
	localparam int KN_ACC_W  = 30;

	// Output magnitudes saturate at these widths
	localparam int LAT_MAG_W = 30;
	localparam int LON_MAG_W = 34;

	// Output fields
	localparam int LAT_OUT_W = 31;
	localparam int LON_OUT_W = 35;
	localparam int SPD_OUT_W = 25;
	localparam int TDATA_W   = 96;
	localparam int PAD_W     = TDATA_W - (LAT_OUT_W + LON_OUT_W + SPD_OUT_W);

	// Conversion datapath depth in cycles
	localparam int SCALE_LAT = 8;

	// ASCII codes
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_W      = 8'h57;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;

	// Field index = commas seen since the header
	localparam logic [COMMA_W-1:0] FLD_STATUS = 4'd2;
	localparam logic [COMMA_W-1:0] FLD_LAT    = 4'd3;
	localparam logic [COMMA_W-1:0] FLD_NS     = 4'd4;
	localparam logic [COMMA_W-1:0] FLD_LON    = 4'd5;
	localparam logic [COMMA_W-1:0] FLD_EW     = 4'd6;
	localparam logic [COMMA_W-1:0] FLD_SPEED  = 4'd7;
	localparam logic [COMMA_W-1:0] MIN_COMMAS = 4'd7;

	// Conversion constants
	localparam longint unsigned E7          = 64'd10_000_000;
	localparam longint unsigned CENT        = 64'd100;
	localparam longint unsigned MIN_PER_DEG = 64'd60;
	localparam longint unsigned KMH_E3_KN   = 64'd1852;

	// Header match progress: number of header characters matched so far
	typedef enum logic [2:0] {
		HP_IDLE,
		HP_DOLLAR,
		HP_G,
		HP_PN,
		HP_R,
		HP_M
	} hdr_t;

	typedef enum logic [1:0] {
		PH_INT,
		PH_FRAC,
		PH_STOP
	} phase_t;

	typedef struct packed {
		logic fix;
		logic south;
		logic west;
	} flags_t;

	typedef struct packed {
		flags_t                 flags;
		logic [LAT_ACC_W-1:0]   lat;
		logic [LON_ACC_W-1:0]   lon;
		logic [KN_ACC_W-1:0]    knots;
	} snap_t;

	function automatic longint unsigned pow10(input int k);
		logic [2:0] kk;
		kk = k[2:0];
		case (kk)
			3'd0: return 64'd1;
			3'd1: return 64'd10;
			3'd2: return 64'd100;
			3'd3: return 64'd1000;
			3'd4: return 64'd10000;
			3'd5: return 64'd100000;
			3'd6: return 64'd1000000;
			default: return 64'd10000000;
		endcase
	endfunction

	// Bits needed to hold values 0..v
	function automatic int width_of(input longint unsigned v);
		return (v < 64'd2) ? 1 : $clog2(v + 64'd1);
	endfunction

endpackage

FILE: rtl/nrmc_cdiv.sv
// Pipelined divide by a constant: reciprocal multiply, then one correction step.
// One item per cycle while en is high. Uses nrmc_pkg.
module nrmc_cdiv #(
	parameter int              W   = 16,
	parameter longint unsigned DIV = 64'd10,
	localparam longint unsigned X_MAX = (64'd1 << W) - 64'd1,
	localparam int              Q_W   = nrmc_pkg::width_of(X_MAX / DIV),
	localparam int              R_W   = nrmc_pkg::width_of(DIV - 64'd1)
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   x,
	output logic [Q_W-1:0] q,
	output logic [R_W-1:0] rem
);

	// floor(2^W / DIV) leaves the estimate at most one short
	localparam longint unsigned M   = (64'd1 << W) / DIV;
	localparam int              M_W = nrmc_pkg::width_of(M);
	localparam int              P_W = W + M_W;

	logic [P_W-1:0] prod_s1;
	logic [W-1:0]   x_s1;
	logic [W-1:0]   x_s2;
	logic [Q_W-1:0] q0_s2;
	logic [W-1:0]   qd_s2;
	logic [Q_W-1:0] q_s3;
	logic [R_W-1:0] rem_s3;

	logic [Q_W-1:0] q0;
	logic [W-1:0]   diff;

	always_comb begin
		q0   = Q_W'(prod_s1 >> W);
		diff = x_s2 - qd_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= P_W'(x) * P_W'(M);
			x_s1    <= x;
			q0_s2   <= q0;
			qd_s2   <= W'(64'(q0) * DIV);
			x_s2    <= x_s1;
			if (64'(diff) >= DIV) begin
				q_s3   <= q0_s2 + 1'b1;
				rem_s3 <= R_W'(64'(diff) - DIV);
			end else begin
				q_s3   <= q0_s2;
				rem_s3 <= R_W'(diff);
			end
		end
	end

	assign q   = q_s3;
	assign rem = rem_s3;

endmodule

FILE: rtl/nrmc_scale.sv
// Fixed-point rescale y = floor(x/DIV_A)*MUL_Q + floor((x mod DIV_A)*MUL_R/DIV_B),
// saturated to OUT_W bits. Uses nrmc_pkg, nrmc_cdiv.
module nrmc_scale #(
	parameter int              IN_W  = 30,
	parameter int              OUT_W = 30,
	parameter longint unsigned DIV_A = 64'd100,
	parameter longint unsigned MUL_Q = 64'd1,
	parameter longint unsigned MUL_R = 64'd1,
	parameter longint unsigned DIV_B = 64'd10
) (
	input  logic             clk,
	input  logic             en,
	input  logic [IN_W-1:0]  x,
	output logic [OUT_W-1:0] y
);

	localparam longint unsigned X_MAX  = (64'd1 << IN_W) - 64'd1;
	localparam longint unsigned Q_MAX  = X_MAX / DIV_A;
	localparam int              Q_W    = nrmc_pkg::width_of(Q_MAX);
	localparam int              R_W    = nrmc_pkg::width_of(DIV_A - 64'd1);
	localparam int              QC_W   = nrmc_pkg::width_of(Q_MAX * MUL_Q);
	localparam int              P_W    = nrmc_pkg::width_of((DIV_A - 64'd1) * MUL_R);
	localparam int              F_W    = nrmc_pkg::width_of(((64'd1 << P_W) - 64'd1) / DIV_B);
	localparam int              SUM_W  = ((QC_W > F_W) ? QC_W : F_W) + 1;
	localparam longint unsigned Y_MAX  = (64'd1 << OUT_W) - 64'd1;

	logic [Q_W-1:0]   q_a;
	logic [R_W-1:0]   r_a;
	logic [QC_W-1:0]  qc_s4, qc_s5, qc_s6, qc_s7;
	logic [P_W-1:0]   p_s4;
	logic [F_W-1:0]   f_b;
	logic [SUM_W-1:0] sum;
	logic [OUT_W-1:0] y_s8;

	nrmc_cdiv #(.W(IN_W), .DIV(DIV_A)) u_div_a (
		.clk (clk),
		.en  (en),
		.x   (x),
		.q   (q_a),
		.rem (r_a)
	);

	nrmc_cdiv #(.W(P_W), .DIV(DIV_B)) u_div_b (
		.clk (clk),
		.en  (en),
		.x   (p_s4),
		.q   (f_b),
		.rem ()
	);

	assign sum = SUM_W'(qc_s7) + SUM_W'(f_b);

	always_ff @(posedge clk) begin
		if (en) begin
			qc_s4 <= QC_W'(64'(q_a) * MUL_Q);
			p_s4  <= P_W'(64'(r_a) * MUL_R);
			qc_s5 <= qc_s4;
			qc_s6 <= qc_s5;
			qc_s7 <= qc_s6;
			y_s8  <= (64'(sum) > Y_MAX) ? {OUT_W{1'b1}} : OUT_W'(sum);
		end
	end

	assign y = y_s8;

endmodule

FILE: rtl/nrmc_parse.sv
// Byte-serial RMC header search, comma counting and field accumulation.
// Emits a registered snapshot of the fields on the last byte. Uses nrmc_pkg.
module nrmc_parse #(
	parameter int FRACTION_DIGITS = nrmc_pkg::FRACTION_DIGITS_DEF,
	parameter int MAX_COMMAS      = nrmc_pkg::MAX_COMMAS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output nrmc_pkg::snap_t   snap
);

	localparam int NW = nrmc_pkg::ACC_W + 6;
	localparam logic [nrmc_pkg::FRAC_W-1:0]  FD_CODE   = nrmc_pkg::FRAC_W'(FRACTION_DIGITS);
	localparam logic [nrmc_pkg::COMMA_W-1:0] COMMA_CAP = nrmc_pkg::COMMA_W'(MAX_COMMAS);
	localparam logic [NW-1:0] INT_SCALE = NW'(nrmc_pkg::pow10(FRACTION_DIGITS));
	localparam logic [nrmc_pkg::ACC_W-1:0] LAT_MAX =
		nrmc_pkg::ACC_W'((64'd1 << nrmc_pkg::LAT_ACC_W) - 64'd1);
	localparam logic [nrmc_pkg::ACC_W-1:0] LON_MAX =
		nrmc_pkg::ACC_W'((64'd1 << nrmc_pkg::LON_ACC_W) - 64'd1);
	localparam logic [nrmc_pkg::ACC_W-1:0] KN_MAX =
		nrmc_pkg::ACC_W'((64'd1 << nrmc_pkg::KN_ACC_W) - 64'd1);

	nrmc_pkg::hdr_t                     hdr_q, hdr_n;
	logic                               found_q, found_n;
	logic [nrmc_pkg::COMMA_W-1:0]       comma_q, comma_n;
	logic [7:0]                         status_q, status_n;
	logic                               south_q, south_n;
	logic                               west_q, west_n;
	logic [nrmc_pkg::LAT_ACC_W-1:0]     lat_q, lat_n;
	logic [nrmc_pkg::LON_ACC_W-1:0]     lon_q, lon_n;
	logic [nrmc_pkg::KN_ACC_W-1:0]      kn_q, kn_n;
	logic [nrmc_pkg::FRAC_W-1:0]        frac_q, frac_n;
	nrmc_pkg::phase_t                   phase_q, phase_n;
	nrmc_pkg::snap_t                    snap_q;

	logic                               hdr_ok;
	logic                               is_digit;
	logic [3:0]                         digit;
	logic [nrmc_pkg::ACC_W-1:0]         acc_sel, acc_max, acc_new;
	logic [NW-1:0]                      acc_ext, v_int, v_frac, v_sel;
	logic [nrmc_pkg::FRAC_W-1:0]        frac_idx;
	logic                               acc_wr;
	logic                               fix_n;

	// Shared number unit: one accumulator is live at a time
	always_comb begin
		is_digit = (data_byte >= nrmc_pkg::CH_0) && (data_byte <= nrmc_pkg::CH_9);
		digit    = data_byte[3:0];
		case (comma_q)
			nrmc_pkg::FLD_LAT: begin
				acc_sel = nrmc_pkg::ACC_W'(lat_q);
				acc_max = LAT_MAX;
			end
			nrmc_pkg::FLD_LON: begin
				acc_sel = lon_q;
				acc_max = LON_MAX;
			end
			default: begin
				acc_sel = nrmc_pkg::ACC_W'(kn_q);
				acc_max = KN_MAX;
			end
		endcase
		acc_ext  = NW'(acc_sel);
		frac_idx = FD_CODE - 1'b1 - frac_q;
		v_int    = (acc_ext << 3) + (acc_ext << 1) + NW'(digit) * INT_SCALE;
		v_frac   = acc_ext + NW'(digit) * NW'(nrmc_pkg::pow10(int'(frac_idx)));
		v_sel    = (phase_q == nrmc_pkg::PH_INT) ? v_int : v_frac;
		acc_new  = (v_sel > NW'(acc_max)) ? acc_max : v_sel[nrmc_pkg::ACC_W-1:0];
	end

	always_comb begin
		case (hdr_q)
			nrmc_pkg::HP_IDLE:   hdr_ok = (data_byte == nrmc_pkg::CH_DOLLAR);
			nrmc_pkg::HP_DOLLAR: hdr_ok = (data_byte == nrmc_pkg::CH_G);
			nrmc_pkg::HP_G:      hdr_ok = (data_byte == nrmc_pkg::CH_P) ||
			                              (data_byte == nrmc_pkg::CH_N);
			nrmc_pkg::HP_PN:     hdr_ok = (data_byte == nrmc_pkg::CH_R);
			nrmc_pkg::HP_R:      hdr_ok = (data_byte == nrmc_pkg::CH_M);
			nrmc_pkg::HP_M:      hdr_ok = (data_byte == nrmc_pkg::CH_C);
			default:             hdr_ok = 1'b0;
		endcase
	end

	always_comb begin
		hdr_n    = hdr_q;
		found_n  = found_q;
		comma_n  = comma_q;
		status_n = status_q;
		south_n  = south_q;
		west_n   = west_q;
		lat_n    = lat_q;
		lon_n    = lon_q;
		kn_n     = kn_q;
		frac_n   = frac_q;
		phase_n  = phase_q;
		acc_wr   = 1'b0;

		if (!found_q) begin
			if (hdr_ok) begin
				if (hdr_q == nrmc_pkg::HP_M) begin
					found_n = 1'b1;
					hdr_n   = nrmc_pkg::HP_IDLE;
				end else begin
					hdr_n = nrmc_pkg::hdr_t'(hdr_q + 1'b1);
				end
			end else begin
				// a stray '$' restarts the match
				hdr_n = (data_byte == nrmc_pkg::CH_DOLLAR) ? nrmc_pkg::HP_DOLLAR
				                                           : nrmc_pkg::HP_IDLE;
			end
		end else if (data_byte == nrmc_pkg::CH_COMMA) begin
			if (comma_q < COMMA_CAP)
				comma_n = comma_q + 1'b1;
			phase_n = nrmc_pkg::PH_INT;
			frac_n  = '0;
		end else begin
			case (comma_q)
				nrmc_pkg::FLD_STATUS: begin
					if (phase_q == nrmc_pkg::PH_INT) begin
						status_n = data_byte;
						phase_n  = nrmc_pkg::PH_STOP;
					end
				end
				nrmc_pkg::FLD_NS: begin
					if (phase_q == nrmc_pkg::PH_INT) begin
						south_n = (data_byte == nrmc_pkg::CH_S);
						phase_n = nrmc_pkg::PH_STOP;
					end
				end
				nrmc_pkg::FLD_EW: begin
					if (phase_q == nrmc_pkg::PH_INT) begin
						west_n  = (data_byte == nrmc_pkg::CH_W);
						phase_n = nrmc_pkg::PH_STOP;
					end
				end
				nrmc_pkg::FLD_LAT, nrmc_pkg::FLD_LON, nrmc_pkg::FLD_SPEED: begin
					case (phase_q)
						nrmc_pkg::PH_INT: begin
							if (is_digit) begin
								acc_wr = 1'b1;
							end else if (data_byte == nrmc_pkg::CH_DOT) begin
								phase_n = nrmc_pkg::PH_FRAC;
								frac_n  = '0;
							end else begin
								phase_n = nrmc_pkg::PH_STOP;
							end
						end
						nrmc_pkg::PH_FRAC: begin
							if (is_digit) begin
								// digits past the kept precision are dropped
								if (frac_q < FD_CODE) begin
									acc_wr = 1'b1;
									frac_n = frac_q + 1'b1;
								end
							end else begin
								phase_n = nrmc_pkg::PH_STOP;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end

		if (acc_wr) begin
			case (comma_q)
				nrmc_pkg::FLD_LAT: lat_n = acc_new[nrmc_pkg::LAT_ACC_W-1:0];
				nrmc_pkg::FLD_LON: lon_n = acc_new[nrmc_pkg::LON_ACC_W-1:0];
				default:           kn_n  = acc_new[nrmc_pkg::KN_ACC_W-1:0];
			endcase
		end

		fix_n = found_n && (comma_n >= nrmc_pkg::MIN_COMMAS) && (status_n == nrmc_pkg::CH_A);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= nrmc_pkg::HP_IDLE;
			found_q  <= 1'b0;
			comma_q  <= '0;
			status_q <= '0;
			south_q  <= 1'b0;
			west_q   <= 1'b0;
			lat_q    <= '0;
			lon_q    <= '0;
			kn_q     <= '0;
			frac_q   <= '0;
			phase_q  <= nrmc_pkg::PH_INT;
		end else if (take) begin
			if (last_byte) begin
				// buffer done: start the next one from scratch
				hdr_q    <= nrmc_pkg::HP_IDLE;
				found_q  <= 1'b0;
				comma_q  <= '0;
				status_q <= '0;
				south_q  <= 1'b0;
				west_q   <= 1'b0;
				lat_q    <= '0;
				lon_q    <= '0;
				kn_q     <= '0;
				frac_q   <= '0;
				phase_q  <= nrmc_pkg::PH_INT;
			end else begin
				hdr_q    <= hdr_n;
				found_q  <= found_n;
				comma_q  <= comma_n;
				status_q <= status_n;
				south_q  <= south_n;
				west_q   <= west_n;
				lat_q    <= lat_n;
				lon_q    <= lon_n;
				kn_q     <= kn_n;
				frac_q   <= frac_n;
				phase_q  <= phase_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_byte) begin
			snap_q.flags.fix   <= fix_n;
			snap_q.flags.south <= south_n;
			snap_q.flags.west  <= west_n;
			snap_q.lat         <= lat_n;
			snap_q.lon         <= lon_n;
			snap_q.knots       <= kn_n;
		end
	end

	assign snap = snap_q;

endmodule

FILE: rtl/nmea_rmc_fix_parser.sv
// Top level of the RMC fix parser: stream ports, conversion pipeline, held fix.
// Uses nrmc_pkg, nrmc_parse, nrmc_scale (which uses nrmc_cdiv).
//
// Usage
//   s_* carries the bytes of one receiver read buffer, one byte per item;
//   s_tlast marks the final byte of the buffer. Bytes before the first
//   $GPRMC/$GNRMC header are skipped; after it, fields are parsed as they
//   stream past, one byte per cycle while s_tready is high.
//   m_* carries one item per buffer, produced by its final byte: m_tuser is
//   the fix flag, m_tdata the held latitude, longitude (degrees * 1e7,
//   signed) and speed (km/h * 1000). A buffer without an active fix
//   reports the previously held values with the flag low.
// Timing
//   One byte per cycle while s_tready is high. The result of a buffer reaches
//   m_tvalid through these registers in order: the field snapshot, captured
//   on the same edge as its last byte is taken, then the constant-divisor
//   conversion (two reciprocal dividers of three stages each plus a multiply
//   and a saturate stage), then the output register.
// Reset and stalls
//   arst_n clears the parser, the pipeline valid bits and the held values.
//   While m_tready is low the finished result waits in the output register;
//   the pipeline and s_tready keep running until a result reaches the tail
//   stage, then everything holds until the output is taken.
module nmea_rmc_fix_parser #(
	parameter int FRACTION_DIGITS = nrmc_pkg::FRACTION_DIGITS_DEF,
	parameter int MAX_COMMAS      = nrmc_pkg::MAX_COMMAS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] data_byte
	input  logic                          s_tlast,   // last_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [nrmc_pkg::TDATA_W-1:0]  m_tdata,   // [30:0] latitude_e7,
	                                                 // [65:31] longitude_e7,
	                                                 // [90:66] speed_kmh_e3, rest 0
	output logic                          m_tuser    // fix_valid
);

	localparam int              L     = nrmc_pkg::SCALE_LAT;
	localparam longint unsigned SCALE = nrmc_pkg::pow10(FRACTION_DIGITS);

	// degrees * 1e7 = floor(raw / (100*s)) * 1e7 + floor((raw mod 100*s) * 1e7 / (60*s)),
	// with the minutes ratio reduced to small constants
	localparam longint unsigned DEG_DIV_A = nrmc_pkg::CENT * SCALE;
	localparam longint unsigned DEG_MUL_R =
		(FRACTION_DIGITS < 7) ? nrmc_pkg::E7 / (64'd10 * SCALE) : 64'd1;
	localparam longint unsigned DEG_DIV_B =
		(FRACTION_DIGITS < 7) ? nrmc_pkg::MIN_PER_DEG / 64'd10 : nrmc_pkg::MIN_PER_DEG;

	logic                              take;
	logic                              out_free;
	logic                              en;
	logic                              load;
	nrmc_pkg::snap_t                   snap;
	logic [L:0]                        vld_s;
	nrmc_pkg::flags_t                  flags_s [1:L];
	logic [nrmc_pkg::LAT_MAG_W-1:0]    lat_mag;
	logic [nrmc_pkg::LON_MAG_W-1:0]    lon_mag;
	logic [nrmc_pkg::SPD_OUT_W-1:0]    spd_mag;
	logic [nrmc_pkg::LAT_OUT_W-1:0]    lat_ext, lat_new;
	logic [nrmc_pkg::LON_OUT_W-1:0]    lon_ext, lon_new;
	logic                              out_vld_q;
	logic                              out_fix_q;
	logic signed [nrmc_pkg::LAT_OUT_W-1:0] held_lat_q;
	logic signed [nrmc_pkg::LON_OUT_W-1:0] held_lon_q;
	logic [nrmc_pkg::SPD_OUT_W-1:0]    held_spd_q;

	// Pipeline moves when the output can take the tail, or the tail is empty
	assign out_free = !out_vld_q || m_tready;
	assign en       = out_free || !vld_s[L];
	assign load     = out_free && vld_s[L];
	assign s_tready = en;
	assign take     = s_tvalid && s_tready;

	nrmc_parse #(
		.FRACTION_DIGITS (FRACTION_DIGITS),
		.MAX_COMMAS      (MAX_COMMAS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (s_tdata),
		.last_byte (s_tlast),
		.snap      (snap)
	);

	nrmc_scale #(
		.IN_W  (nrmc_pkg::LAT_ACC_W),
		.OUT_W (nrmc_pkg::LAT_MAG_W),
		.DIV_A (DEG_DIV_A),
		.MUL_Q (nrmc_pkg::E7),
		.MUL_R (DEG_MUL_R),
		.DIV_B (DEG_DIV_B)
	) u_lat (
		.clk (clk),
		.en  (en),
		.x   (snap.lat),
		.y   (lat_mag)
	);

	nrmc_scale #(
		.IN_W  (nrmc_pkg::LON_ACC_W),
		.OUT_W (nrmc_pkg::LON_MAG_W),
		.DIV_A (DEG_DIV_A),
		.MUL_Q (nrmc_pkg::E7),
		.MUL_R (DEG_MUL_R),
		.DIV_B (DEG_DIV_B)
	) u_lon (
		.clk (clk),
		.en  (en),
		.x   (snap.lon),
		.y   (lon_mag)
	);

	// km/h * 1000 = knots_raw * 1852 / s, split into quotient and remainder
	nrmc_scale #(
		.IN_W  (nrmc_pkg::KN_ACC_W),
		.OUT_W (nrmc_pkg::SPD_OUT_W),
		.DIV_A (SCALE),
		.MUL_Q (nrmc_pkg::KMH_E3_KN),
		.MUL_R (nrmc_pkg::KMH_E3_KN),
		.DIV_B (SCALE)
	) u_spd (
		.clk (clk),
		.en  (en),
		.x   (snap.knots),
		.y   (spd_mag)
	);

	// Hemisphere sign applied on the saturated magnitudes
	always_comb begin
		lat_ext = {1'b0, lat_mag};
		lon_ext = {1'b0, lon_mag};
		lat_new = flags_s[L].south ? (~lat_ext + 1'b1) : lat_ext;
		lon_new = flags_s[L].west  ? (~lon_ext + 1'b1) : lon_ext;
	end

	// Flags ride alongside the conversion stages
	always_ff @(posedge clk) begin
		if (en) begin
			flags_s[1] <= snap.flags;
			for (int i = 2; i <= L; i++)
				flags_s[i] <= flags_s[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s      <= '0;
			out_vld_q  <= 1'b0;
			out_fix_q  <= 1'b0;
			held_lat_q <= '0;
			held_lon_q <= '0;
			held_spd_q <= '0;
		end else begin
			if (en)
				vld_s <= {vld_s[L-1:0], take && s_tlast};
			if (out_free)
				out_vld_q <= vld_s[L];
			if (load) begin
				out_fix_q <= flags_s[L].fix;
				// an inactive buffer reports the values already held
				if (flags_s[L].fix) begin
					held_lat_q <= lat_new;
					held_lon_q <= lon_new;
					held_spd_q <= spd_mag;
				end
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_fix_q;
	assign m_tdata  = {{nrmc_pkg::PAD_W{1'b0}}, held_spd_q, held_lon_q, held_lat_q};

endmodule

FILE: tb/testbench.sv
// Self-checking bench for nmea_rmc_fix_parser: streams GPS read buffers byte by byte
// and checks each buffer's fix item against an in-bench RMC parser.
// Depends on nrmc_pkg and nmea_rmc_fix_parser from rtl/.
module testbench;
	import nrmc_pkg::*;

	localparam int IDLE_PCT     = 20;      // chance per cycle that a side idles
	localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
	localparam int DRAIN_CYCLES = 24;      // wait after the last fix item is checked
	localparam int TIMEOUT      = 400000;  // time units
	localparam int FRAC_DIG     = FRACTION_DIGITS_DEF;

	localparam longint unsigned LAT_ACC_CAP = (64'd1 << LAT_ACC_W) - 1;
	localparam longint unsigned LON_ACC_CAP = (64'd1 << LON_ACC_W) - 1;
	localparam longint unsigned KN_ACC_CAP  = (64'd1 << KN_ACC_W) - 1;
	localparam longint unsigned LAT_MAG_CAP = (64'd1 << LAT_MAG_W) - 1;
	localparam longint unsigned LON_MAG_CAP = (64'd1 << LON_MAG_W) - 1;
	localparam longint unsigned SPD_CAP     = (64'd1 << SPD_OUT_W) - 1;

	typedef struct packed {
		logic                 fix;
		logic [LAT_OUT_W-1:0] lat;
		logic [LON_OUT_W-1:0] lon;
		logic [SPD_OUT_W-1:0] spd;
	} fix_report_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata  = 8'd0;
	logic               s_tlast  = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;

	nmea_rmc_fix_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// Parser copy: per-buffer scan state plus the held fix
	hdr_t                 hdr       = HP_IDLE;
	logic                 found     = 1'b0;
	logic [COMMA_W-1:0]   commas    = '0;
	logic [7:0]           status    = 8'd0;
	logic                 south     = 1'b0;
	logic                 west      = 1'b0;
	logic [LAT_ACC_W-1:0] lat_acc   = '0;
	logic [LON_ACC_W-1:0] lon_acc   = '0;
	logic [KN_ACC_W-1:0]  kn_acc    = '0;
	int                   frac_cnt  = 0;
	phase_t               num_phase = PH_INT;
	logic [LAT_OUT_W-1:0] held_lat  = '0;
	logic [LON_OUT_W-1:0] held_lon  = '0;
	logic [SPD_OUT_W-1:0] held_spd  = '0;

	fix_report_t expected_fixes[$];
	logic [7:0]  pending[$];     // bytes of the buffer being built
	int          mismatches = 0;
	int          bytes_sent = 0;
	bit          steady     = 1'b0;   // no idling on either side
	bit          hold_req   = 1'b0;
	int          hold_left  = 0;

	function automatic longint unsigned ten_pow(int k);
		longint unsigned p;
		p = 1;
		repeat (k) p = p * 10;
		return p;
	endfunction

	// One byte of a decimal field; accumulator holds value * 10^FRAC_DIG
	function automatic longint unsigned take_number(longint unsigned acc,
			longint unsigned cap, logic [7:0] b);
		logic            is_digit;
		longint unsigned v;
		is_digit = (b >= CH_0) && (b <= CH_9);
		v = acc;
		case (num_phase)
			PH_INT: begin
				if (is_digit)
					v = acc * 10 + (b - CH_0) * ten_pow(FRAC_DIG);
				else if (b == CH_DOT) begin
					num_phase = PH_FRAC;
					frac_cnt = 0;
				end else
					num_phase = PH_STOP;
			end
			PH_FRAC: begin
				if (!is_digit)
					num_phase = PH_STOP;
				else if (frac_cnt < FRAC_DIG) begin
					// digits past the kept precision are dropped
					v = acc + (b - CH_0) * ten_pow(FRAC_DIG - 1 - frac_cnt);
					frac_cnt++;
				end
			end
			default: ;
		endcase
		return (v > cap) ? cap : v;
	endfunction

	// ddmm.m / dddmm.m to degrees * 1e7, truncating
	function automatic longint unsigned deg_e7(longint unsigned acc, longint unsigned cap);
		longint unsigned whole, rest, v;
		whole = acc / (CENT * ten_pow(FRAC_DIG));
		rest  = acc - whole * CENT * ten_pow(FRAC_DIG);
		v     = whole * E7 + rest * E7 / (MIN_PER_DEG * ten_pow(FRAC_DIG));
		return (v > cap) ? cap : v;
	endfunction

	function automatic void parse_rmc_byte(logic [7:0] b, logic last);
		logic            match;
		logic            fix;
		longint unsigned mag;
		longint unsigned kmh;
		if (!found) begin
			case (hdr)
				HP_IDLE:   match = (b == CH_DOLLAR);
				HP_DOLLAR: match = (b == CH_G);
				HP_G:      match = (b == CH_P) || (b == CH_N);
				HP_PN:     match = (b == CH_R);
				HP_R:      match = (b == CH_M);
				HP_M:      match = (b == CH_C);
				default:   match = 1'b0;
			endcase
			if (match) begin
				if (hdr == HP_M) begin
					found = 1'b1;
					hdr = HP_IDLE;
				end else
					hdr = hdr_t'(hdr + 3'd1);
			end else if (b == CH_DOLLAR)
				hdr = HP_DOLLAR;   // a '$' restarts the match
			else
				hdr = HP_IDLE;
		end else if (b == CH_COMMA) begin
			if (commas < MAX_COMMAS_DEF)
				commas++;
			num_phase = PH_INT;
			frac_cnt = 0;
		end else begin
			case (commas)
				FLD_STATUS: if (num_phase == PH_INT) begin
					status = b;
					num_phase = PH_STOP;
				end
				FLD_LAT:   lat_acc = LAT_ACC_W'(take_number(lat_acc, LAT_ACC_CAP, b));
				FLD_NS:    if (num_phase == PH_INT) begin
					south = (b == CH_S);
					num_phase = PH_STOP;
				end
				FLD_LON:   lon_acc = LON_ACC_W'(take_number(lon_acc, LON_ACC_CAP, b));
				FLD_EW:    if (num_phase == PH_INT) begin
					west = (b == CH_W);
					num_phase = PH_STOP;
				end
				FLD_SPEED: kn_acc = KN_ACC_W'(take_number(kn_acc, KN_ACC_CAP, b));
				default: ;
			endcase
		end
		if (last) begin
			fix = found && (commas >= MIN_COMMAS) && (status == CH_A);
			if (fix) begin
				mag = deg_e7(lat_acc, LAT_MAG_CAP);
				held_lat = LAT_OUT_W'(south ? 64'd0 - mag : mag);
				mag = deg_e7(lon_acc, LON_MAG_CAP);
				held_lon = LON_OUT_W'(west ? 64'd0 - mag : mag);
				kmh = kn_acc * KMH_E3_KN / ten_pow(FRAC_DIG);
				held_spd = SPD_OUT_W'((kmh > SPD_CAP) ? SPD_CAP : kmh);
			end
			expected_fixes.push_back('{fix, held_lat, held_lon, held_spd});
			// everything but the held fix starts over with the next buffer
			hdr = HP_IDLE;
			found = 1'b0;
			commas = '0;
			status = 8'd0;
			south = 1'b0;
			west = 1'b0;
			lat_acc = '0;
			lon_acc = '0;
			kn_acc = '0;
			frac_cnt = 0;
			num_phase = PH_INT;
		end
	endfunction

	// Sender: random gaps before each item unless steady
	task automatic send_byte(logic [7:0] b, logic last);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		parse_rmc_byte(b, last);
		bytes_sent++;
	endtask

	task automatic flush_buffer();
		for (int i = 0; i < pending.size(); i++)
			send_byte(pending[i], i == pending.size() - 1);
		pending.delete();
	endtask

	function automatic void put(string s);
		for (int i = 0; i < s.len(); i++)
			pending.push_back(s[i]);
	endfunction

	function automatic void put_byte(logic [7:0] b);
		pending.push_back(b);
	endfunction

	function automatic void put_digits(int n);
		repeat (n) pending.push_back(8'(CH_0 + $urandom_range(9)));
	endfunction

	function automatic void put_rand_number();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return;                            // empty field
		if (r < 16) begin
			put_digits($urandom_range(12, 8));  // drives the accumulator to saturation
			return;
		end
		put_digits($urandom_range(5));
		if ($urandom_range(99) < 80) begin
			put(".");
			put_digits($urandom_range(8));
		end
		if ($urandom_range(99) < 8) begin
			put_byte(8'($urandom_range(255)));
			put_digits($urandom_range(3));
		end
	endfunction

	function automatic void put_rand_letter(string a, string b);
		case ($urandom_range(9))
			0, 1, 2, 3: put(a);
			4, 5, 6, 7: put(b);
			8: ;
			default: put_byte(8'($urandom_range(255)));
		endcase
	endfunction

	// Mostly well-formed RMC sentences with random content; some noise,
	// broken headers, trailing sentences and truncated buffers
	function automatic void build_rand_buffer();
		int cut;
		if ($urandom_range(99) < 10) begin
			repeat ($urandom_range(40, 1)) put_byte(8'($urandom_range(255)));
			return;
		end
		if ($urandom_range(99) < 30)
			repeat ($urandom_range(6, 1)) put_byte(8'($urandom_range(255)));
		repeat (($urandom_range(99) < 15) ? 2 : 1) begin
			case ($urandom_range(19))
				18: put("$GP$GNRMC");
				19: put(($urandom_range(1) != 0) ? "$GPRMX" : "$GNGGA");
				default: put(($urandom_range(1) != 0) ? "$GPRMC" : "$GNRMC");
			endcase
			put(",");
			put_digits(6);
			put(".00,");
			case ($urandom_range(19))
				0, 1: put("V");
				2:    ;
				3:    put_byte(8'($urandom_range(255)));
				4:    put("AV");
				default: put("A");
			endcase
			put(",");
			put_rand_number();
			put(",");
			put_rand_letter("N", "S");
			put(",");
			put_rand_number();
			put(",");
			put_rand_letter("E", "W");
			put(",");
			put_rand_number();
			if ($urandom_range(99) < 70)
				put(",084.4,230394,003.1,W*6A");
			if ($urandom_range(99) < 60)
				put("\r\n");
		end
		if ($urandom_range(99) < 12) begin
			cut = $urandom_range(pending.size(), 1);
			while (pending.size() > cut)
				void'(pending.pop_back());
		end
	endfunction

	// Receiver: random stalls, or a counted hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin : check_fix_items
		fix_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_fixes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected fix item: flag=%0b tdata=%h", m_tuser, m_tdata);
			end else begin
				want = expected_fixes.pop_front();
				if (m_tuser !== want.fix
						|| m_tdata[LAT_OUT_W-1:0] !== want.lat
						|| m_tdata[LAT_OUT_W +: LON_OUT_W] !== want.lon
						|| m_tdata[LAT_OUT_W+LON_OUT_W +: SPD_OUT_W] !== want.spd) begin
					mismatches++;
					if (mismatches <= 10)
						$display("fix mismatch: want %0b %0d %0d %0d, got %0b %0d %0d %0d",
							want.fix, $signed(want.lat), $signed(want.lon), want.spd,
							m_tuser, $signed(m_tdata[LAT_OUT_W-1:0]),
							$signed(m_tdata[LAT_OUT_W +: LON_OUT_W]),
							m_tdata[LAT_OUT_W+LON_OUT_W +: SPD_OUT_W]);
				end
			end
		end
	end

	task automatic test_header_search();
		// junk, then '$' breaking partial matches at several depths
		put("junk$GP$GPRM$GNRMC,1,A,8959.99999,S,17959.99999,W,999.99999,1");
		flush_buffer();
		put("$GPRMX,1,A,1,N,1,E,1,");
		flush_buffer();
		put("GPRMC,1,A,1,N,1,E,1,$$GNRMC,,A,4530.5,N,00730.25,E,5,");
		flush_buffer();
		put("$");
		flush_buffer();
		put("C");
		flush_buffer();
		// only the first header counts, GPRMC is not preferred over GNRMC
		put("$GNRMC,1,V,1,N,1,E,1,,*00\r\n$GPRMC,1,A,5,N,5,E,5,,\r\n");
		flush_buffer();
		// commas saturate well before a 4-bit wrap
		put("$GPRMC,1,A,0102.5,N,00304.5,E,7.5,,,,,,,,,,,,,,,,,,");
		flush_buffer();
		put("$GPRMC$GPRMC,,A,1,N,1,E,1,");
		flush_buffer();
		// a header split over two buffers is not a header
		put("$GPR");
		flush_buffer();
		put("MC,,A,1,N,1,E,1,");
		flush_buffer();
	endtask

	task automatic test_field_parsing();
		put("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n");
		flush_buffer();
		put("$GNRMC,000000.00,A,0000.00000,S,00000.00000,W,0.0,,,,,A*00");
		flush_buffer();
		put("$GPRMC,,A,1234.123456789,S,12345.98765432,W,12.3456789,");
		flush_buffer();
		put("$GPRMC,,A,99999999999,N,999999999999,E,99999999999,");
		flush_buffer();
		put("$GPRMC,,A,,,,,,");              // empty fields give zero
		flush_buffer();
		put("$GPRMC,1,A,1,N,1,E");           // six commas only
		flush_buffer();
		put("$GPRMC,1,V,1234.5,N,01234.5,E,1.0,");
		flush_buffer();
		put("$GPRMC,1,AV,12.3.4,s,1x23,w,5.5.5,");
		flush_buffer();
		put("$GPRMC,1,VA,1,N,1,E,1,");
		flush_buffer();
		put("$GPRMC,1,A,.5,SN,.25,WE,.75,");
		flush_buffer();
		// speed field comes from a later sentence since commas keep counting
		put("$GPRMC,1,A,3000,N,4000,E\r\n$GPGGA,2,3.5,4");
		flush_buffer();
		// NUL and high bytes stop a number like any other character
		put("$GPRMC,1,A,12");
		put_byte(8'h00);
		put("34,N,");
		put_byte(8'hFF);
		put("99,E,");
		put_byte(8'h80);
		put("1,");
		flush_buffer();
	endtask

	// Receiver holds off while short buffers keep coming, so the block backs up
	task automatic test_backpressure();
		steady = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < 36; i++) begin
			if (i % 4 == 0) begin
				put("$GPRMC,,A,");
				put_digits(4);
				put(",S,");
				put_digits(5);
				put(",W,");
				put_digits(2);
				put(",");
			end else
				put("x");
			flush_buffer();
		end
		steady = 1'b0;
	endtask

	task automatic test_random_buffers();
		int nbuf;
		nbuf = 0;
		bytes_sent = 0;
		while (bytes_sent < 500) begin
			steady = (nbuf >= 2) && (nbuf < 6);
			build_rand_buffer();
			flush_buffer();
			nbuf++;
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_search();
		test_field_parsing();
		test_backpressure();
		test_random_buffers();
		s_tvalid <= 1'b0;
		while (expected_fixes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** nmea_rmc_fix_parser: PASSED **");
		else
			$display("** nmea_rmc_fix_parser: FAILED **");
		$finish;
	end

	initial begin
		#TIMEOUT;
		$display("timeout with %0d fix items outstanding", expected_fixes.size());
		$display("** nmea_rmc_fix_parser: FAILED **");
		$finish;
	end

endmodule
